// ===== rtl/core/assert_macros.svh =====
// Assertion helpers used by the bound checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Clocked assertion that also holds across reset.
`define ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/core/pmb_pkg.sv =====
`timescale 1ns / 1ps
package pmb_pkg;

    // Operation codes of the operation register.
    typedef enum logic [2:0] {
        OP_ADD     = 3'd0,
        OP_SUB     = 3'd1,
        OP_MUL     = 3'd2,
        OP_DIV     = 3'd3,
        OP_MIN     = 3'd4,
        OP_MAX     = 3'd5,
        OP_LOG     = 3'd6,
        OP_MUL_ALT = 3'd7
    } t_op;

    // Configuration register indexes.
    localparam logic [0:0] REG_OPERATION = 1'b0;
    localparam logic [0:0] REG_CLAMP     = 1'b1;

    // log2(1 + i/16) in Q1.16, i = 0 .. 16.
    localparam logic [16:0] LOG_TAB [17] = '{
        17'd0,     17'd5732,  17'd11136, 17'd16248, 17'd21098, 17'd25711,
        17'd30109, 17'd34312, 17'd38336, 17'd42196, 17'd45904, 17'd49472,
        17'd52911, 17'd56229, 17'd59434, 17'd62537, 17'd65536
    };

endpackage

// ===== rtl/core/pixel_math_blend_core.sv =====
// Pixel arithmetic and blend core. Each accepted transaction carries a blend factor
// (unsigned, FRAC_BITS fraction bits, one = 2**FRAC_BITS) and two signed fixed-point
// channel values a and b. The operation register selects add, subtract, multiply,
// divide, minimum, maximum or the log ratio log2(a)/log2(b); codes not listed act as
// multiply. The core returns fac*op + (1-fac)*a, rounded to nearest and saturated,
// optionally clamped to the range zero to one, together with an error flag that is
// raised on a division by zero or an invalid logarithm. The core takes one
// transaction in every clock cycle unless it stalls, and returns one result per
// transaction, in order. A shared restoring divider, as wide as the larger of
// VALUE_WIDTH and 24, resolves one quotient bit per pipeline stage and serves both
// the divide and the log ratio. The pipeline stalls as a whole only when the output
// register is held and the stage before it is occupied, so bubbles are squeezed out
// while the downstream side waits. Configuration may only be written while the core
// holds no transaction.
`timescale 1ns / 1ps
module pixel_math_blend_core #(
    parameter int FRAC_BITS   = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    // Input stream.
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // tdata, from bit 0: blend_factor, value_a, value_b, zero padding.
    input  logic [((FRAC_BITS + 1 + 2 * VALUE_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
    // Output stream.
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // tdata, from bit 0: blended, zero padding.
    output logic [((VALUE_WIDTH + 7) / 8) * 8 - 1:0] m_axis_tdata,
    // tuser, from bit 0: math_error.
    output logic [0:0] m_axis_tuser,
    // Configuration write port.
    input  logic       i_cfg_we,
    input  logic [0:0] i_cfg_index,
    input  logic [2:0] i_cfg_data
);
    import pmb_pkg::*;

    localparam int VW    = VALUE_WIDTH;
    localparam int F     = FRAC_BITS;
    localparam int FW    = FRAC_BITS + 1;
    localparam int OUT_W = ((VALUE_WIDTH + 7) / 8) * 8;
    localparam int PW    = $clog2(VALUE_WIDTH);
    localparam int LW    = 24;
    localparam int MW    = (VALUE_WIDTH > LW) ? VALUE_WIDTH : LW;
    localparam int NW    = MW + FRAC_BITS;
    localparam int H     = VALUE_WIDTH / 2;
    localparam int PRW   = 2 * VALUE_WIDTH;
    localparam int BW    = FRAC_BITS + VALUE_WIDTH + 3;
    localparam int SW    = (PRW + 1 > BW) ? PRW + 1 : BW;

    localparam logic signed [VW-1:0] VMAX = {1'b0, {(VW - 1){1'b1}}};
    localparam logic signed [VW-1:0] VMIN = {1'b1, {(VW - 1){1'b0}}};
    localparam logic signed [SW-1:0] VMAX_S = SW'(VMAX);
    localparam logic signed [SW-1:0] VMIN_S = SW'(VMIN);
    localparam logic [FW-1:0] ONE_FAC = FW'(1) << FRAC_BITS;
    localparam bit ONE_FITS = (FRAC_BITS <= VALUE_WIDTH - 2);
    localparam logic signed [VW-1:0] CLAMP_TOP =
        ONE_FITS ? $signed(VW'(1) << FRAC_BITS) : VMAX;
    localparam logic [NW-1:0] Q_NEG_LIM = NW'(1) << (VALUE_WIDTH - 1);
    localparam logic [NW-1:0] Q_POS_LIM = Q_NEG_LIM - NW'(1);
    localparam logic [SW-1:0] HALF_LSB = SW'(1) << (FRAC_BITS - 1);

    // Payload that rides alongside the divider.
    typedef struct packed {
        logic [FW-1:0]        fac;
        logic signed [VW-1:0] a;
        logic signed [VW-1:0] alt;
        logic                 use_q;
        logic                 neg;
        logic                 err;
    } t_side;

    function automatic logic signed [VW-1:0] sat_v(input logic signed [SW-1:0] v);
        if (v > VMAX_S) begin
            return VMAX;
        end else if (v < VMIN_S) begin
            return VMIN;
        end
        return v[VW-1:0];
    endfunction

    function automatic logic [PW-1:0] lead_one(input logic [VW-1:0] u);
        logic [PW-1:0] p;
        p = '0;
        for (int i = 0; i < VW; i++) begin
            if (u[i]) begin
                p = PW'(i);
            end
        end
        return p;
    endfunction

    function automatic logic [15:0] norm_frac(input logic [VW-1:0] u,
                                              input logic [PW-1:0] p);
        logic [VW+15:0] ext;
        logic [PW-1:0]  sh;
        sh  = PW'(VW - 1) - p;
        ext = {u, 16'h0000} << sh;
        return ext[VW+14 -: 16];
    endfunction

    function automatic logic signed [LW-1:0] log_val(input logic [PW-1:0] p,
                                                     input logic [15:0] f);
        logic [4:0]            i0;
        logic [4:0]            i1;
        logic [16:0]           lo;
        logic [16:0]           hi;
        logic [28:0]           pr;
        logic [16:0]           inter;
        logic signed [LW-1:0]  ip;
        i0    = {1'b0, f[15:12]};
        i1    = i0 + 5'd1;
        lo    = LOG_TAB[i0];
        hi    = LOG_TAB[i1];
        pr    = 29'(hi - lo) * 29'(f[11:0]);
        inter = 17'((pr + 29'd2048) >> 12);
        ip    = $signed(LW'(p)) - $signed(LW'(FRAC_BITS));
        ip    = ip <<< 16;
        return ip + $signed(LW'(lo)) + $signed(LW'(inter));
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers and flow control
    // ------------------------------------------------------------------
    t_op  r_operation;
    logic r_clamp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_operation <= OP_ADD;
            r_clamp     <= 1'b0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_OPERATION) begin
                r_operation <= t_op'(i_cfg_data);
            end else begin
                r_clamp <= i_cfg_data[0];
            end
        end
    end

    logic r_out_v;
    logic r_b2_v;
    logic en;
    logic out_load;

    // The output register loads whenever it is free or being drained; the rest of the
    // pipeline may also move on while the output waits, as long as its last stage is
    // empty, which lets a new transaction in behind a stalled result.
    assign out_load      = !r_out_v || m_axis_tready;
    assign en            = out_load || !r_b2_v;
    assign s_axis_tready = en;

    // ------------------------------------------------------------------
    // Stage 1: capture, limit the blend factor to one
    // ------------------------------------------------------------------
    logic                 r_p1_v;
    logic [FW-1:0]        r_p1_fac;
    logic signed [VW-1:0] r_p1_a;
    logic signed [VW-1:0] r_p1_b;
    logic [FW-1:0]        in_fac;

    assign in_fac = s_axis_tdata[FW-1:0];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p1_fac <= (in_fac > ONE_FAC) ? ONE_FAC : in_fac;
            r_p1_a   <= s_axis_tdata[FW +: VW];
            r_p1_b   <= s_axis_tdata[FW + VW +: VW];
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: simple operations, partial products, leading-one positions
    // ------------------------------------------------------------------
    logic                   r_p2_v;
    logic [FW-1:0]          r_p2_fac;
    logic signed [VW-1:0]   r_p2_a;
    logic signed [VW-1:0]   r_p2_b;
    logic signed [VW-1:0]   r_p2_simple;
    logic signed [VW+H:0]   r_p2_pp_lo;
    logic signed [PRW-H-1:0] r_p2_pp_hi;
    logic [PW-1:0]          r_p2_pa;
    logic [PW-1:0]          r_p2_pb;
    logic                   r_p2_bz;
    logic                   r_p2_lbad;

    logic signed [VW:0]     n_sum;
    logic signed [VW:0]     n_diff;
    logic signed [VW-1:0]   n_simple;

    always_comb begin
        n_sum  = {r_p1_a[VW-1], r_p1_a} + {r_p1_b[VW-1], r_p1_b};
        n_diff = {r_p1_a[VW-1], r_p1_a} - {r_p1_b[VW-1], r_p1_b};
        case (r_operation)
            OP_ADD:  n_simple = sat_v(SW'(n_sum));
            OP_SUB:  n_simple = sat_v(SW'(n_diff));
            OP_MIN:  n_simple = (r_p1_a < r_p1_b) ? r_p1_a : r_p1_b;
            OP_MAX:  n_simple = (r_p1_a > r_p1_b) ? r_p1_a : r_p1_b;
            default: n_simple = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p2_fac    <= r_p1_fac;
            r_p2_a      <= r_p1_a;
            r_p2_b      <= r_p1_b;
            r_p2_simple <= n_simple;
            r_p2_pp_lo  <= r_p1_a * $signed({1'b0, r_p1_b[H-1:0]});
            r_p2_pp_hi  <= r_p1_a * $signed(r_p1_b[VW-1:H]);
            r_p2_pa     <= lead_one(r_p1_a);
            r_p2_pb     <= lead_one(r_p1_b);
            r_p2_bz     <= (r_p1_b == '0);
            r_p2_lbad   <= r_p1_a[VW-1] || (r_p1_a == '0) ||
                           r_p1_b[VW-1] || (r_p1_b == '0);
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: full product, normalised mantissas for the logarithm
    // ------------------------------------------------------------------
    logic                   r_p3_v;
    logic [FW-1:0]          r_p3_fac;
    logic signed [VW-1:0]   r_p3_a;
    logic signed [VW-1:0]   r_p3_b;
    logic signed [VW-1:0]   r_p3_simple;
    logic signed [PRW-1:0]  r_p3_prod;
    logic [15:0]            r_p3_fa;
    logic [15:0]            r_p3_fb;
    logic [PW-1:0]          r_p3_pa;
    logic [PW-1:0]          r_p3_pb;
    logic                   r_p3_bz;
    logic                   r_p3_lbad;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p3_fac    <= r_p2_fac;
            r_p3_a      <= r_p2_a;
            r_p3_b      <= r_p2_b;
            r_p3_simple <= r_p2_simple;
            r_p3_prod   <= (PRW'(r_p2_pp_hi) <<< H) + PRW'(r_p2_pp_lo);
            r_p3_fa     <= norm_frac(r_p2_a, r_p2_pa);
            r_p3_fb     <= norm_frac(r_p2_b, r_p2_pb);
            r_p3_pa     <= r_p2_pa;
            r_p3_pb     <= r_p2_pb;
            r_p3_bz     <= r_p2_bz;
            r_p3_lbad   <= r_p2_lbad;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: rounded product, log2 of both operands
    // ------------------------------------------------------------------
    logic                   r_p4_v;
    logic [FW-1:0]          r_p4_fac;
    logic signed [VW-1:0]   r_p4_a;
    logic signed [VW-1:0]   r_p4_b;
    logic signed [VW-1:0]   r_p4_simple;
    logic signed [VW-1:0]   r_p4_mul;
    logic signed [LW-1:0]   r_p4_la;
    logic signed [LW-1:0]   r_p4_lb;
    logic                   r_p4_bz;
    logic                   r_p4_lbad;
    logic signed [SW-1:0]   n_mul_rnd;

    assign n_mul_rnd = (SW'(r_p3_prod) + $signed(HALF_LSB)) >>> F;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p4_fac    <= r_p3_fac;
            r_p4_a      <= r_p3_a;
            r_p4_b      <= r_p3_b;
            r_p4_simple <= r_p3_simple;
            r_p4_mul    <= sat_v(n_mul_rnd);
            r_p4_la     <= log_val(r_p3_pa, r_p3_fa);
            r_p4_lb     <= log_val(r_p3_pb, r_p3_fb);
            r_p4_bz     <= r_p3_bz;
            r_p4_lbad   <= r_p3_lbad;
        end
    end

    // ------------------------------------------------------------------
    // Divider entry: choose operands, or settle the result now
    // ------------------------------------------------------------------
    t_side          n_side;
    logic [MW-1:0]  n_dv_mag;
    logic [MW-1:0]  n_dv_d;
    logic [VW-1:0]  mag_a;
    logic [VW-1:0]  mag_b;
    logic [LW-1:0]  mag_la;
    logic [LW-1:0]  mag_lb;

    always_comb begin
        mag_a  = r_p4_a[VW-1] ? VW'(-r_p4_a) : r_p4_a;
        mag_b  = r_p4_b[VW-1] ? VW'(-r_p4_b) : r_p4_b;
        mag_la = r_p4_la[LW-1] ? LW'(-r_p4_la) : r_p4_la;
        mag_lb = r_p4_lb[LW-1] ? LW'(-r_p4_lb) : r_p4_lb;
        n_side.fac   = r_p4_fac;
        n_side.a     = r_p4_a;
        n_side.alt   = r_p4_mul;
        n_side.use_q = 1'b0;
        n_side.neg   = 1'b0;
        n_side.err   = 1'b0;
        n_dv_mag     = MW'(mag_a);
        n_dv_d       = MW'(mag_b);
        case (r_operation)
            OP_ADD, OP_SUB, OP_MIN, OP_MAX: begin
                n_side.alt = r_p4_simple;
            end
            OP_DIV: begin
                if (r_p4_bz) begin
                    // Division by zero: saturate in the direction of a.
                    n_side.err = 1'b1;
                    if (r_p4_a[VW-1]) begin
                        n_side.alt = VMIN;
                    end else if (r_p4_a == '0) begin
                        n_side.alt = '0;
                    end else begin
                        n_side.alt = VMAX;
                    end
                end else begin
                    n_side.use_q = 1'b1;
                    n_side.neg   = r_p4_a[VW-1] ^ r_p4_b[VW-1];
                end
            end
            OP_LOG: begin
                if (r_p4_lbad || (r_p4_lb == '0)) begin
                    n_side.err = 1'b1;
                    n_side.alt = VMAX;
                end else begin
                    n_side.use_q = 1'b1;
                    n_side.neg   = r_p4_la[LW-1] ^ r_p4_lb[LW-1];
                    n_dv_mag     = MW'(mag_la);
                    n_dv_d       = MW'(mag_lb);
                end
            end
            default: begin
                n_side.alt = r_p4_mul;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Restoring divider, one quotient bit per stage
    // ------------------------------------------------------------------
    logic          r_dv_v    [0:NW];
    logic [NW-1:0] r_dv_num  [0:NW];
    logic [MW-1:0] r_dv_rem  [0:NW];
    logic [MW-1:0] r_dv_d    [0:NW];
    t_side         r_dv_side [0:NW];
    logic [NW-1:0] n_dv_num  [0:NW-1];
    logic [MW-1:0] n_dv_rem  [0:NW-1];

    always_comb begin
        logic [MW:0] rem_sh;
        logic        ge;
        for (int k = 0; k < NW; k++) begin
            rem_sh      = {r_dv_rem[k], r_dv_num[k][NW-1]};
            ge          = (rem_sh >= {1'b0, r_dv_d[k]});
            n_dv_rem[k] = ge ? MW'(rem_sh - {1'b0, r_dv_d[k]}) : rem_sh[MW-1:0];
            n_dv_num[k] = {r_dv_num[k][NW-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dv_num[0]  <= {n_dv_mag, F'(0)};
            r_dv_rem[0]  <= '0;
            r_dv_d[0]    <= n_dv_d;
            r_dv_side[0] <= n_side;
            for (int k = 0; k < NW; k++) begin
                r_dv_num[k+1]  <= n_dv_num[k];
                r_dv_rem[k+1]  <= n_dv_rem[k];
                r_dv_d[k+1]    <= r_dv_d[k];
                r_dv_side[k+1] <= r_dv_side[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Quotient sign and saturation
    // ------------------------------------------------------------------
    logic                 r_pq_v;
    logic [FW-1:0]        r_pq_fac;
    logic signed [VW-1:0] r_pq_a;
    logic signed [VW-1:0] r_pq_op;
    logic                 r_pq_err;
    logic signed [VW-1:0] n_op;
    logic [NW-1:0]        q;
    logic [NW-1:0]        q_neg;
    t_side                side_q;

    always_comb begin
        side_q = r_dv_side[NW];
        q      = r_dv_num[NW];
        q_neg  = -q;
        if (!side_q.use_q) begin
            n_op = side_q.alt;
        end else if (side_q.neg) begin
            n_op = (q > Q_NEG_LIM) ? VMIN : $signed(q_neg[VW-1:0]);
        end else begin
            n_op = (q > Q_POS_LIM) ? VMAX : $signed(q[VW-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pq_fac <= side_q.fac;
            r_pq_a   <= side_q.a;
            r_pq_op  <= n_op;
            r_pq_err <= side_q.err;
        end
    end

    // ------------------------------------------------------------------
    // Blend: two weighted products, then sum, round, saturate, clamp
    // ------------------------------------------------------------------
    logic                   r_b1_v;
    logic signed [BW-2:0]   r_b1_m1;
    logic signed [BW-2:0]   r_b1_m2;
    logic                   r_b1_err;
    logic signed [SW-1:0]   n_blend;
    logic signed [VW-1:0]   n_res_sat;
    logic signed [VW-1:0]   n_res;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b1_m1  <= $signed({1'b0, r_pq_fac}) * r_pq_op;
            r_b1_m2  <= $signed({1'b0, FW'(ONE_FAC - r_pq_fac)}) * r_pq_a;
            r_b1_err <= r_pq_err;
        end
    end

    always_comb begin
        n_blend   = (SW'(r_b1_m1) + SW'(r_b1_m2) + $signed(HALF_LSB)) >>> F;
        n_res_sat = sat_v(n_blend);
        n_res     = n_res_sat;
        if (r_clamp) begin
            if (n_res_sat > CLAMP_TOP) begin
                n_res = CLAMP_TOP;
            end else if (n_res_sat[VW-1]) begin
                n_res = '0;
            end
        end
    end

    logic [VW-1:0] r_b2_res;
    logic          r_b2_err;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b2_res <= n_res;
            r_b2_err <= r_b1_err;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic [VW-1:0] r_out_blended;
    logic          r_out_err;

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_blended <= r_b2_res;
            r_out_err     <= r_b2_err;
        end
    end

    // Valid bits travel with the data and are the only reset state of the pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_v  <= 1'b0;
            r_p2_v  <= 1'b0;
            r_p3_v  <= 1'b0;
            r_p4_v  <= 1'b0;
            r_pq_v  <= 1'b0;
            r_b1_v  <= 1'b0;
            r_b2_v  <= 1'b0;
            r_out_v <= 1'b0;
            for (int k = 0; k <= NW; k++) begin
                r_dv_v[k] <= 1'b0;
            end
        end else begin
            if (en) begin
                r_p1_v    <= s_axis_tvalid;
                r_p2_v    <= r_p1_v;
                r_p3_v    <= r_p2_v;
                r_p4_v    <= r_p3_v;
                r_dv_v[0] <= r_p4_v;
                for (int k = 0; k < NW; k++) begin
                    r_dv_v[k+1] <= r_dv_v[k];
                end
                r_pq_v <= r_dv_v[NW];
                r_b1_v <= r_pq_v;
                r_b2_v <= r_b1_v;
            end
            if (out_load) begin
                r_out_v <= r_b2_v;
            end
        end
    end

    assign m_axis_tvalid   = r_out_v;
    assign m_axis_tdata    = OUT_W'(r_out_blended);
    assign m_axis_tuser[0] = r_out_err;

endmodule

// ===== rtl/core/pmb_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pmb_checker #(
    parameter int FRAC_BITS   = 16,
    parameter int VALUE_WIDTH = 32
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic s_axis_tvalid,
    input logic s_axis_tready,
    input logic [((FRAC_BITS + 1 + 2 * VALUE_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
    input logic m_axis_tvalid,
    input logic m_axis_tready,
    input logic [((VALUE_WIDTH + 7) / 8) * 8 - 1:0] m_axis_tdata,
    input logic [0:0] m_axis_tuser,
    input logic       i_cfg_we,
    input logic [0:0] i_cfg_index,
    input logic [2:0] i_cfg_data
);
    import pmb_pkg::*;

    // Shadow of the clamp enable, seen from the configuration port.
    logic r_clamp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clamp <= 1'b0;
        end else if (i_cfg_we && (i_cfg_index == REG_CLAMP)) begin
            r_clamp <= i_cfg_data[0];
        end
    end

    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed or vanished")
    `ASSERT_CLK(a_ready_when_empty, i_clk, i_rst_n, !m_axis_tvalid |-> s_axis_tready, "input blocked with an empty output register")
    `ASSERT_CLK(a_clamp_nonneg, i_clk, i_rst_n, r_clamp && m_axis_tvalid |-> !m_axis_tdata[VALUE_WIDTH-1], "clamped result is negative")
    `ASSERT_RST(a_reset_empty, i_clk, !i_rst_n |=> !m_axis_tvalid, "result shown straight after reset")

    // Input valid and data are not checked here beyond being visible to the bind.
    logic unused_in;
    assign unused_in = s_axis_tvalid ^ (^s_axis_tdata);

endmodule

bind pixel_math_blend_core pmb_checker #(
    .FRAC_BITS   (FRAC_BITS),
    .VALUE_WIDTH (VALUE_WIDTH)
) u_pmb_checker (.*);

// ===== tb/sv/pmb_blend_checker.sv =====
`timescale 1ns / 1ps
module pmb_blend_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [87:0] i_in_data,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [31:0] i_out_data,
    input  logic [0:0]  i_out_user,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [2:0]  i_cfg_data,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked,
    output int          o_errors_seen
);
    import pmb_pkg::*;

    localparam longint UNITY = 64'sd65536;
    localparam longint VMAX  = 64'sd2147483647;
    localparam longint VMIN  = -64'sd2147483648;

    typedef struct packed {
        logic [31:0] blended;
        logic        math_error;
    } t_pixel_result;

    t_pixel_result expected_pixels[$];
    t_op           cur_op;
    logic          cur_clamp;

    function automatic longint sat_value(longint v);
        return (v > VMAX) ? VMAX : ((v < VMIN) ? VMIN : v);
    endfunction

    // Round to nearest with ties upward, drop the fraction, then saturate.
    function automatic longint round_frac(longint v);
        return sat_value((v + 64'sd32768) >>> 16);
    endfunction

    // Leading-one position plus interpolated table gives log2 in Q.16.
    function automatic longint approx_log2(longint x);
        int     p;
        longint f;
        longint lo;
        longint hi;
        int     idx;
        p = 31;
        while (p > 0 && x[p] == 1'b0) p--;
        if (p >= 16) f = (x >> (p - 16)) & 64'hFFFF;
        else         f = (x << (16 - p)) & 64'hFFFF;
        idx = int'(f >> 12);
        lo  = longint'(LOG_TAB[idx]);
        hi  = longint'(LOG_TAB[idx + 1]);
        return longint'(p - 16) * 65536 + lo + (((hi - lo) * (f & 64'hFFF) + 2048) >>> 12);
    endfunction

    function automatic t_pixel_result blend_pixel(logic [87:0] item);
        t_pixel_result r;
        longint fac;
        longint a;
        longint b;
        longint op;
        longint la;
        longint lb;
        longint mix;
        fac = longint'(item[16:0]);
        a   = longint'(signed'(item[48:17]));
        b   = longint'(signed'(item[80:49]));
        r.math_error = 1'b0;
        if (fac > UNITY) fac = UNITY;
        case (cur_op)
            OP_ADD: op = sat_value(a + b);
            OP_SUB: op = sat_value(a - b);
            OP_DIV: begin
                if (b == 0) begin
                    r.math_error = 1'b1;
                    op = (a > 0) ? VMAX : ((a < 0) ? VMIN : 0);
                end else begin
                    op = sat_value((a * UNITY) / b);
                end
            end
            OP_MIN: op = (a < b) ? a : b;
            OP_MAX: op = (a > b) ? a : b;
            OP_LOG: begin
                op = VMAX;
                if (a <= 0 || b <= 0) begin
                    r.math_error = 1'b1;
                end else begin
                    la = approx_log2(a);
                    lb = approx_log2(b);
                    if (lb == 0) r.math_error = 1'b1;
                    else         op = sat_value((la * UNITY) / lb);
                end
            end
            default: op = round_frac(a * b);
        endcase
        mix = round_frac(fac * op + (UNITY - fac) * a);
        if (cur_clamp) begin
            if (mix > UNITY) mix = UNITY;
            if (mix < 0)     mix = 0;
        end
        r.blended = mix[31:0];
        return r;
    endfunction

    assign o_pending = expected_pixels.size();

    always @(posedge i_clk) begin
        t_pixel_result got;
        t_pixel_result want;
        int            fails;
        fails = 0;
        if (!i_rst_n) begin
            cur_op        <= OP_ADD;
            cur_clamp     <= 1'b0;
            o_fail_count  <= 0;
            o_checked     <= 0;
            o_errors_seen <= 0;
            expected_pixels.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == REG_OPERATION) cur_op    <= t_op'(i_cfg_data);
                else                              cur_clamp <= i_cfg_data[0];
            end
            if (i_out_valid && i_out_ready) begin
                got.blended    = i_out_data;
                got.math_error = i_out_user[0];
                o_checked     <= o_checked + 1;
                o_errors_seen <= o_errors_seen + got.math_error;
                if (expected_pixels.size() == 0) begin
                    $error("result transaction with nothing expected: blended %h", got.blended);
                    fails++;
                end else begin
                    want = expected_pixels.pop_front();
                    if (got.blended !== want.blended) begin
                        $error("blended: expected %h, actual %h", want.blended, got.blended);
                        fails++;
                    end
                    if (got.math_error !== want.math_error) begin
                        $error("math_error: expected %b, actual %b",
                               want.math_error, got.math_error);
                        fails++;
                    end
                end
            end
            o_fail_count <= o_fail_count + fails;
            // The push follows the pop, so same-cycle pass-through could not break ordering.
            if (i_in_valid && i_in_ready) expected_pixels.push_back(blend_pixel(i_in_data));
        end
    end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
    import pmb_pkg::*;

    // A cap on consecutive cycles without any transaction; the longest legitimate quiet
    // spell covers the pipeline draining plus the settle waits before register writes.
    localparam int QUIET_LIMIT = 5000;
    localparam int SETTLE      = 80;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [87:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;
    logic        i_cfg_we = 1'b0;
    logic [0:0]  i_cfg_index = '0;
    logic [2:0]  i_cfg_data = '0;

    int fail_count;
    int pending;
    int checked;
    int errors_seen;
    int quiet_cycles = 0;
    // Percentages of cycles in which the sender idles and the receiver stalls.
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    pixel_math_blend_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    pmb_blend_checker checker_inst (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (s_axis_tvalid),
        .i_in_ready    (s_axis_tready),
        .i_in_data     (s_axis_tdata),
        .i_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .i_out_data    (m_axis_tdata),
        .i_out_user    (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_checked     (checked),
        .o_errors_seen (errors_seen)
    );

    // The receiver decides afresh at every edge whether it will stall in the next cycle.
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // The watchdog ends the run if neither side moves a transaction for too long.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Offers one transaction and returns at the edge where it is accepted. Idle cycles
    // go before the offer, so valid is only lowered when a gap is actually wanted.
    task automatic push_pixel(logic [16:0] fac, logic [31:0] a, logic [31:0] b);
        if ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, b, a, fac};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Registers are only written once the pipeline is empty: the sender stops, all
    // expected results are collected, and then the pipeline depth is allowed to pass.
    task automatic write_register(logic [0:0] index, logic [2:0] value);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Mixes the extremes, unit-scale values, exact one, zero and raw random words.
    function automatic logic [31:0] pick_value();
        case ($urandom_range(9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'd0;
            3: return 32'h0001_0000;
            4, 5: return $urandom;
            default: return {{12{1'b0}}, 20'($urandom)} - 32'h0008_0000;
        endcase
    endfunction

    function automatic logic [16:0] pick_factor();
        case ($urandom_range(5))
            0: return 17'd0;
            1: return 17'd65536;
            2: return 17'($urandom_range(131071, 65537));
            default: return 17'($urandom_range(65536));
        endcase
    endfunction

    // Edge cases: both extremes, division by zero with each sign of a, non-positive
    // logarithm arguments, log2(b) of zero, and factors of zero, one and beyond one.
    logic [16:0] dir_fac[12] = '{17'd65536, 17'd65536, 17'd0, 17'h1FFFF, 17'd65536,
                                 17'd65536, 17'd32768, 17'd65536, 17'd65536, 17'd1,
                                 17'd65536, 17'd98304};
    logic [31:0] dir_a[12]   = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'd1, 32'd0,
                                 32'h0001_0000, 32'hFFFF_0000, 32'h0002_0000, 32'hFFFF_FFFF,
                                 32'h7FFF_FFFF, 32'h0003_0000, 32'd12345};
    logic [31:0] dir_b[12]   = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                                 32'd0, 32'h0001_0000, 32'd0, 32'h0004_0000, 32'd1,
                                 32'h8000_0000, 32'd0, 32'hFFFF_FFF9};

    initial begin
        int      phase;
        int      n;
        logic [31:0] va;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Sixteen phases: every operation code with clamping off and then on, and the
        // four idling patterns rotating underneath them.
        for (phase = 0; phase < 16; phase++) begin
            write_register(REG_OPERATION, 3'(phase % 8));
            write_register(REG_CLAMP, 3'(phase / 8));
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
                default: begin send_idle_pct = 26; recv_stall_pct = 26; end
            endcase
            if (phase < 8) begin
                for (n = 0; n < 12; n++) push_pixel(dir_fac[n], dir_a[n], dir_b[n]);
            end
            for (n = 0; n < 100; n++) begin
                va = pick_value();
                // The log ratio needs positive operands to get past its error checks,
                // so in that phase most pairs are kept positive.
                if (phase % 8 == OP_LOG && $urandom_range(3) != 0) begin
                    push_pixel(pick_factor(), {1'b0, va[30:0]} | 32'd1,
                               ($urandom_range(4) == 0) ? 32'h0001_0000
                                                        : {1'b0, 31'($urandom)} | 32'd1);
                end else begin
                    push_pixel(pick_factor(), va, pick_value());
                end
            end
        end

        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        $display("Covered %0d results over all eight operation codes, clamping off and on,",
                 checked);
        $display("with %0d raising the error flag, under four idling patterns.", errors_seen);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/pmb_pkg.sv
rtl/core/pixel_math_blend_core.sv
rtl/core/pmb_checker.sv
tb/sv/pmb_blend_checker.sv
tb/sv/testbench.sv
